// File: rtl/ipv4pm_pkg.sv
package ipv4pm_pkg;

  // result classes
  localparam logic [1:0] CLASS_NONE    = 2'd0;
  localparam logic [1:0] CLASS_PARTIAL = 2'd1;
  localparam logic [1:0] CLASS_ADDR    = 2'd2;
  localparam logic [1:0] CLASS_PREFIX  = 2'd3;

  // characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned OCTET_MAX  = 255;
  localparam int unsigned MASK_MAX   = 32;
  localparam logic [5:0]  MASK_SAT   = 6'd33;
  localparam logic [2:0]  OCTETS_ALL = 3'd4;
  localparam logic [1:0]  DOTS_ALL   = 2'd3;
  localparam logic [1:0]  DIGITS_ALL = 2'd3;

  typedef struct packed {
    logic       failed;
    logic       in_mask_part;
    logic [1:0] dot_count;
    logic [1:0] octet_digits;
    logic [9:0] octet_value;
    logic [2:0] octet_count;
    logic [5:0] mask_value;
    logic       mask_digits_seen;
  } tok_state_t;

endpackage

// File: rtl/ipv4pm_token.sv
module ipv4pm_token (
  input  ipv4pm_pkg::tok_state_t st,
  input  logic [7:0]             char_code,
  input  logic                   prefix_mode,
  output ipv4pm_pkg::tok_state_t st_nxt,
  output logic                   is_delim,
  output logic [1:0]             match_class
);
  import ipv4pm_pkg::*;

  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] octet_sum;
  logic [9:0]  mask_sum;

  assign is_delim = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                    (char_code == CH_LF) || (char_code == CH_NUL);
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit    = 4'(char_code - CH_ZERO);

  // octet value stays at or below 255 while the token is alive
  assign octet_sum = 12'(st.octet_value) * 12'd10 + 12'(digit);
  assign mask_sum  = 10'(st.mask_value) * 10'd10 + 10'(digit);

  // class of the token seen so far
  always_comb begin
    if (st.failed) begin
      match_class = CLASS_NONE;
    end else if (st.in_mask_part) begin
      if (st.octet_count < OCTETS_ALL || !st.mask_digits_seen) begin
        match_class = CLASS_PARTIAL;
      end else if (st.mask_value > 6'(MASK_MAX)) begin
        match_class = CLASS_NONE;
      end else begin
        match_class = CLASS_PREFIX;
      end
    end else if (st.octet_digits == 2'd0) begin
      match_class = CLASS_NONE;
    end else if (prefix_mode) begin
      match_class = CLASS_PARTIAL;
    end else if (st.octet_count + 3'd1 < OCTETS_ALL) begin
      match_class = CLASS_PARTIAL;
    end else begin
      match_class = CLASS_ADDR;
    end
  end

  always_comb begin
    st_nxt = st;
    if (is_delim) begin
      st_nxt = '0;
    end else if (!st.failed) begin
      if (st.in_mask_part) begin
        // mask chars after a partial address are ignored
        if (st.octet_count >= OCTETS_ALL) begin
          if (is_digit) begin
            if (st.mask_value < MASK_SAT) begin
              st_nxt.mask_value = (mask_sum > 10'(MASK_SAT)) ? MASK_SAT : 6'(mask_sum);
            end
            st_nxt.mask_digits_seen = 1'b1;
          end else begin
            st_nxt.failed = 1'b1;
          end
        end
      end else if (is_digit) begin
        if (st.octet_digits >= DIGITS_ALL) begin
          st_nxt.failed = 1'b1;
        end else begin
          st_nxt.octet_value  = 10'(octet_sum);
          st_nxt.octet_digits = st.octet_digits + 2'd1;
          if (octet_sum > 12'(OCTET_MAX)) begin
            st_nxt.failed = 1'b1;
          end
        end
      end else if (char_code == CH_DOT) begin
        if (st.octet_digits == 2'd0 || st.dot_count >= DOTS_ALL) begin
          st_nxt.failed = 1'b1;
        end else begin
          st_nxt.dot_count    = st.dot_count + 2'd1;
          st_nxt.octet_count  = (st.octet_count < OCTETS_ALL) ? st.octet_count + 3'd1
                                                              : st.octet_count;
          st_nxt.octet_digits = 2'd0;
          st_nxt.octet_value  = 10'd0;
        end
      end else if (char_code == CH_SLASH && prefix_mode) begin
        if (st.octet_digits == 2'd0) begin
          st_nxt.failed = 1'b1;
        end else begin
          st_nxt.octet_count  = (st.octet_count < OCTETS_ALL) ? st.octet_count + 3'd1
                                                              : st.octet_count;
          st_nxt.octet_digits = 2'd0;
          st_nxt.octet_value  = 10'd0;
          st_nxt.in_mask_part = 1'b1;
        end
      end else begin
        st_nxt.failed = 1'b1;
      end
    end
  end

endmodule

// File: rtl/ipv4_prefix_token_matcher_unit.sv
// Channel | Direction | Ports                               | Payload
// in      | slave     | in_tvalid, in_tready, in_tdata      | char_code [7:0]
// out     | master    | out_tvalid, out_tready, out_tdata   | match_class [1:0], zero fill
// cfg     | write     | cfg_wr_en, cfg_wr_data              | prefix_mode
//
// One character per clock while no delimiter waits on a stalled result. A character
// sits in the input register, where it updates the token state; a delimiter that
// leaves it loads the result register, which then presents the class.
// Reset clears the token state, prefix_mode and both valid flags.
// A stalled result stops the next delimiter and all after it; earlier characters flow.
module ipv4_prefix_token_matcher_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] char_code
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [1:0] match_class, [7:2] zero
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data  // prefix_mode
);
  import ipv4pm_pkg::*;

  logic       prefix_mode_r;
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  tok_state_t tok_r;
  tok_state_t tok_nxt;
  logic       is_delim;
  logic [1:0] tok_class;
  logic       s1_adv;
  logic       out_valid_r;
  logic [1:0] out_class_r;

  ipv4pm_token u_token (
    .st          (tok_r),
    .char_code   (s1_char_r),
    .prefix_mode (prefix_mode_r),
    .st_nxt      (tok_nxt),
    .is_delim    (is_delim),
    .match_class (tok_class)
  );

  // a delimiter needs room in the result register
  assign s1_adv    = s1_valid_r && (!is_delim || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_class_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      prefix_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (s1_adv) begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && is_delim) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // load the class on a delimiter transfer
  always_ff @(posedge clk) begin
    if (s1_adv && is_delim) begin
      out_class_r <= tok_class;
    end
  end

endmodule

// File: bench/ipv4_prefix_token_matcher_unit_tb.sv
`timescale 1ns / 1ps

module ipv4_prefix_token_matcher_unit_tb;
  import ipv4pm_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 8;
  localparam int SETTLE       = 4;
  localparam int IDLE_LIMIT   = 2000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;          // [7:0] char_code
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;              // [1:0] match_class, [7:2] zero
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;     // prefix_mode

  ipv4_prefix_token_matcher_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  logic       prefix_mode_q = 1'b0;
  tok_state_t tok = '0;
  logic [1:0] class_q[$];

  logic [7:0] token_buf[$];
  int         chars_sent = 0;
  int         tokens_sent = 0;
  int         error_count = 0;
  int         class_seen[4] = '{0, 0, 0, 0};
  int         idle_cycles = 0;
  bit         in_gaps_on = 1'b1;
  bit         rx_stall_on = 1'b1;
  int         rx_hold_request = 0;
  int         rx_hold_left = 0;
  int         roll;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic bit is_delim(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_NUL;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // close the running octet; an empty one fails the token
  function automatic void close_octet();
    if (tok.octet_digits == 0) begin
      tok.failed = 1'b1;
      return;
    end
    if (tok.octet_count < OCTETS_ALL) tok.octet_count++;
    tok.octet_digits = '0;
    tok.octet_value  = '0;
  endfunction

  function automatic logic [1:0] token_class();
    if (tok.failed) return CLASS_NONE;
    if (tok.in_mask_part) begin
      if (tok.octet_count < OCTETS_ALL || !tok.mask_digits_seen) return CLASS_PARTIAL;
      return (tok.mask_value > MASK_MAX) ? CLASS_NONE : CLASS_PREFIX;
    end
    if (tok.octet_digits == 0) return CLASS_NONE;
    if (prefix_mode_q) return CLASS_PARTIAL;
    return (tok.octet_count + 1 < OCTETS_ALL) ? CLASS_PARTIAL : CLASS_ADDR;
  endfunction

  function automatic void predict_char(input logic [7:0] c);
    int v;
    if (is_delim(c)) begin
      class_q.push_back(token_class());
      tok = '0;
      tokens_sent++;
      return;
    end
    if (tok.failed) return;
    if (tok.in_mask_part) begin
      // a partial address swallows the whole mask part
      if (tok.octet_count < OCTETS_ALL) return;
      if (is_digit(c)) begin
        v = tok.mask_value;
        if (v < MASK_SAT) begin
          v = v * 10 + (c - CH_ZERO);
          if (v > MASK_SAT) v = MASK_SAT;
        end
        tok.mask_value       = 6'(v);
        tok.mask_digits_seen = 1'b1;
      end else begin
        tok.failed = 1'b1;
      end
    end else if (is_digit(c)) begin
      if (tok.octet_digits >= DIGITS_ALL) begin
        tok.failed = 1'b1;
        return;
      end
      v = tok.octet_value * 10 + (c - CH_ZERO);
      tok.octet_value = 10'(v);
      tok.octet_digits++;
      if (v > OCTET_MAX) tok.failed = 1'b1;
    end else if (c == CH_DOT) begin
      if (tok.octet_digits == 0 || tok.dot_count >= DOTS_ALL) begin
        tok.failed = 1'b1;
        return;
      end
      tok.dot_count++;
      close_octet();
    end else if (c == CH_SLASH && prefix_mode_q) begin
      close_octet();
      if (!tok.failed) tok.in_mask_part = 1'b1;
    end else begin
      tok.failed = 1'b1;
    end
  endfunction

  function automatic int draw_in_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!in_gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = draw_in_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_char(c);
    chars_sent++;
  endtask

  task automatic send_chars(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_token(input string s, input logic [7:0] delim);
    send_chars(s);
    send_char(delim);
  endtask

  // drop valid, wait for every expected class, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (class_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    prefix_mode_q = mode;
  endtask

  function automatic void push_number(input int value, input int width);
    logic [7:0] digs[$];
    int v;
    v = value;
    do begin
      digs.push_front(8'(CH_ZERO + v % 10));
      v = v / 10;
    end while (v > 0);
    while (digs.size() < width) digs.push_front(CH_ZERO);
    foreach (digs[i]) token_buf.push_back(digs[i]);
  endfunction

  // mostly well-formed addresses and prefixes, with broken and noisy ones mixed in
  function automatic void build_random_token();
    int n_oct;
    int r;
    token_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 5)) token_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n_oct = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 4;
    for (int i = 0; i < n_oct; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        // leave the octet empty
      end else if (r < 4) begin
        push_number($urandom_range(0, 999), $urandom_range(1, 4));
      end else begin
        push_number($urandom_range(0, 255), 0);
      end
      if (i < n_oct - 1) token_buf.push_back(CH_DOT);
    end
    if ($urandom_range(0, 2) != 0) begin
      token_buf.push_back(CH_SLASH);
      r = $urandom_range(0, 9);
      if (r == 1 || r == 2) push_number($urandom_range(0, 999999), $urandom_range(1, 7));
      else if (r > 2) push_number($urandom_range(0, 40), 0);
    end
    if ($urandom_range(0, 7) == 0)
      token_buf.insert($urandom_range(0, token_buf.size()), 8'($urandom_range(0, 255)));
  endfunction

  task automatic send_random_token();
    logic [7:0] delim;
    build_random_token();
    foreach (token_buf[i]) send_char(token_buf[i]);
    case ($urandom_range(0, 3))
      0:       delim = CH_SPACE;
      1:       delim = CH_TAB;
      2:       delim = CH_LF;
      default: delim = CH_NUL;
    endcase
    send_char(delim);
  endtask

  task automatic test_plain_addresses();
    write_mode(1'b0);
    send_token("255.0.0.255", CH_SPACE);
    send_token("", CH_NUL);
    send_token("1.2", CH_TAB);
    send_token("1.2.3.", CH_LF);
    send_token("1.256", CH_SPACE);
    send_token("1234", CH_SPACE);
    send_token("1..2", CH_SPACE);
    send_token("1.2.3.4.5", CH_SPACE);
    send_token("1.2.3.4/8", CH_SPACE);
    send_char(8'hFF);
    send_char(CH_SPACE);
    drain_results();
  endtask

  task automatic test_prefix_tokens();
    write_mode(1'b1);
    send_token("10.0.0.0/32", CH_SPACE);
    send_token("10.0.0.0/33", CH_TAB);
    send_token("1.2.3.4/0009", CH_LF);
    send_token("1.2.3.4/999999", CH_NUL);
    send_token("1.2.3.4/", CH_SPACE);
    send_token("1.2.3.4", CH_SPACE);
    send_token("1.2/x9/", CH_SPACE);
    send_token("1.2.3.4/3/", CH_SPACE);
    send_token("/8", CH_SPACE);
    send_token("1.2.3.4/a", CH_SPACE);
    send_token("", CH_SPACE);
    drain_results();
  endtask

  // flip the mode while a token is open
  task automatic test_mode_change_in_token();
    write_mode(1'b1);
    send_chars("1.2.3.4/");
    drain_results();
    write_mode(1'b0);
    send_token("24", CH_SPACE);
    send_chars("1.2.3.4");
    drain_results();
    write_mode(1'b1);
    send_token("/16", CH_SPACE);
    send_chars("1.2.3");
    drain_results();
    write_mode(1'b0);
    send_token(".4", CH_SPACE);
    drain_results();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    write_mode(1'b0);
    in_gaps_on = 1'b0;
    rx_hold_request = 250;
    repeat (10) begin
      send_token("1.2.3.4", CH_SPACE);
      send_token("9", CH_LF);
    end
    drain_results();
    in_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int n_chars);
    int start;
    int phase;
    int n;
    start = chars_sent;
    phase = 0;
    while (chars_sent - start < n_chars) begin
      in_gaps_on  = (phase % 2 == 0);
      rx_stall_on = (phase % 3 != 1);
      write_mode(1'(phase % 2) ^ ($urandom_range(0, 3) == 0));
      repeat (12) send_random_token();
      // leave a token open across the next mode write
      if ($urandom_range(0, 1) == 1) begin
        build_random_token();
        n = $urandom_range(0, token_buf.size());
        for (int i = 0; i < n; i++) send_char(token_buf[i]);
      end
      drain_results();
      phase++;
    end
    in_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (rx_hold_request > 0) begin
      rx_hold_left = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left--;
    end else if (!rx_stall_on) begin
      out_tready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        rx_hold_left = (roll < 97) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin : result_check
    logic [1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (class_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual tdata %02h", $time, out_tdata);
      end else begin
        want = class_q.pop_front();
        class_seen[want]++;
        if (out_tdata !== {6'b0, want}) begin
          error_count++;
          $display("%0t: match_class mismatch, expected %02h, actual %02h",
                   $time, {6'b0, want}, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, class_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_plain_addresses();
    test_prefix_tokens();
    test_mode_change_in_token();
    test_output_backpressure();
    test_random_traffic(800);

    if (class_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time, class_q.size());
    end
    $display("Sent %0d characters in %0d tokens, both modes, mode flips inside tokens.",
             chars_sent, tokens_sent);
    $display("Classes checked: none %0d, partial %0d, address %0d, prefix %0d.",
             class_seen[CLASS_NONE], class_seen[CLASS_PARTIAL],
             class_seen[CLASS_ADDR], class_seen[CLASS_PREFIX]);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
